>>> rtl/zalu_pkg.sv
// Shared types and constants of the 16-bit virtual-machine ALU and compare unit.
`timescale 1ns / 1ps

package zalu_pkg;

  localparam int DATA_W               = 16;
  localparam int COUNT_W              = 3;
  localparam int MAX_COMPARE_OPERANDS = 4;
  localparam int JE_LIMIT             = (MAX_COMPARE_OPERANDS < 4) ? MAX_COMPARE_OPERANDS : 4;
  localparam int DIV_STEPS_PER_STAGE  = 2;
  localparam int DIV_STAGES           = DATA_W / DIV_STEPS_PER_STAGE;
  localparam int PIPE_LATENCY         = DIV_STAGES + 2;

  typedef enum logic [3:0] {
    FN_ADD    = 4'd0,
    FN_SUB    = 4'd1,
    FN_MUL    = 4'd2,
    FN_DIV    = 4'd3,
    FN_REM    = 4'd4,
    FN_SHIFT  = 4'd5,
    FN_ASHIFT = 4'd6,
    FN_OR     = 4'd7,
    FN_AND    = 4'd8,
    FN_NOT    = 4'd9,
    FN_TEST   = 4'd10,
    FN_JZ     = 4'd11,
    FN_JE     = 4'd12,
    FN_JL     = 4'd13,
    FN_JG     = 4'd14
  } func_t;

  typedef struct packed {
    func_t             func;
    logic [DATA_W-1:0] value;
    logic              value_valid;
    logic              cond;
    logic              branch_valid;
    logic              dz;
    logic              q_neg;
    logic              r_neg;
  } side_t;

endpackage

>>> rtl/zalu_div.sv
// Pipelined restoring divider for unsigned 16-bit words, carrying side data along.
`timescale 1ns / 1ps

module zalu_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  zalu_pkg::side_t              in_side,
  input  logic [zalu_pkg::DATA_W-1:0]  in_dividend,
  input  logic [zalu_pkg::DATA_W-1:0]  in_divisor,
  output logic                         out_valid,
  output zalu_pkg::side_t              out_side,
  output logic [zalu_pkg::DATA_W-1:0]  out_quotient,
  output logic [zalu_pkg::DATA_W-1:0]  out_remainder
);

  localparam int W  = zalu_pkg::DATA_W;
  localparam int NS = zalu_pkg::DIV_STAGES;

  logic            valid  [NS];
  zalu_pkg::side_t side   [NS];
  logic [W-1:0]    rem    [NS];
  logic [W-1:0]    quo    [NS];
  logic [W-1:0]    dvs    [NS];

  function automatic logic [2*W-1:0] div_step(input logic [W-1:0] r, input logic [W-1:0] q,
                                               input logic [W-1:0] d);
    logic [W:0] t;
    logic [W:0] diff;
    t    = {r, q[W-1]};
    diff = t - {1'b0, d};
    if (t >= {1'b0, d}) begin
      return {diff[W-1:0], q[W-2:0], 1'b1};
    end
    return {t[W-1:0], q[W-2:0], 1'b0};
  endfunction

  for (genvar g = 0; g < NS; g++) begin : g_stage
    logic            v_in;
    zalu_pkg::side_t s_in;
    logic [W-1:0]    r_in;
    logic [W-1:0]    q_in;
    logic [W-1:0]    d_in;
    logic [2*W-1:0]  acc;

    if (g == 0) begin : g_first
      assign v_in = in_valid;
      assign s_in = in_side;
      assign r_in = '0;
      assign q_in = in_dividend;
      assign d_in = in_divisor;
    end else begin : g_next
      assign v_in = valid[g-1];
      assign s_in = side[g-1];
      assign r_in = rem[g-1];
      assign q_in = quo[g-1];
      assign d_in = dvs[g-1];
    end

    always_comb begin
      acc = {r_in, q_in};
      for (int k = 0; k < zalu_pkg::DIV_STEPS_PER_STAGE; k++) begin
        acc = div_step(acc[2*W-1:W], acc[W-1:0], d_in);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        valid[g] <= 1'b0;
      end else begin
        valid[g] <= v_in;
      end
      side[g] <= s_in;
      rem[g]  <= acc[2*W-1:W];
      quo[g]  <= acc[W-1:0];
      dvs[g]  <= d_in;
    end
  end

  assign out_valid     = valid[NS-1];
  assign out_side      = side[NS-1];
  assign out_quotient  = quo[NS-1];
  assign out_remainder = rem[NS-1];

endmodule

>>> rtl/zmachine_alu_compare_unit_core.sv
// Top level of the 16-bit virtual-machine ALU and compare unit.
`timescale 1ns / 1ps

// Usage:
//   Command channel: drive func, the four operand words and operand_count, and raise
//   start; the word is taken at a rising edge where start is high and busy is low.
//   Result channel: done is high for exactly one cycle with result_value,
//   value_valid, branch_condition, branch_valid and divide_by_zero; the word is
//   taken at the edge that ends that cycle.
//   Path: every instruction takes the same path; the operand stage loads at the
//   accepting edge, then eight divider stages of two restoring steps each and the
//   result register follow, and done is driven from the result register.
//   Results leave in the order the commands came in.
//   Throughput: one instruction per cycle; busy stays low after reset.
//   Reset: rst is synchronous; it empties the pipeline and holds busy high
//   through the reset cycle. No state survives between instructions.
//   The receiver cannot stall: results must be taken in the cycle done is high.
//   Unused func code fifteen yields all-zero result fields.

module zmachine_alu_compare_unit_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [3:0]                     func,
  input  logic [zalu_pkg::DATA_W-1:0]    first_operand,
  input  logic [zalu_pkg::DATA_W-1:0]    second_operand,
  input  logic [zalu_pkg::DATA_W-1:0]    third_operand,
  input  logic [zalu_pkg::DATA_W-1:0]    fourth_operand,
  input  logic [zalu_pkg::COUNT_W-1:0]   operand_count,
  output logic                           done,
  output logic [zalu_pkg::DATA_W-1:0]    result_value,
  output logic                           value_valid,
  output logic                           branch_condition,
  output logic                           branch_valid,
  output logic                           divide_by_zero
);

  localparam int W = zalu_pkg::DATA_W;

  logic                       accept;
  zalu_pkg::func_t            fn;
  zalu_pkg::side_t            side_next;
  logic [W-1:0]               a;
  logic [W-1:0]               b;
  logic [W-1:0]               a_abs;
  logic [W-1:0]               b_abs;
  logic [W-1:0]               shl;
  logic [W-1:0]               shr_l;
  logic [W-1:0]               shr_a;
  logic [W-1:0]               neg_b;
  logic                       shift_left;
  logic                       left_big;
  logic                       right_big;
  logic [W-1:0]               lsh_val;
  logic [W-1:0]               ash_val;
  logic [zalu_pkg::COUNT_W-1:0] cnt_lim;

  logic                       s1_valid;
  zalu_pkg::side_t            s1_side;
  logic [W-1:0]               s1_dividend;
  logic [W-1:0]               s1_divisor;

  logic                       dv_valid;
  zalu_pkg::side_t            dv_side;
  logic [W-1:0]               dv_quo;
  logic [W-1:0]               dv_rem;
  logic [W-1:0]               q_signed;
  logic [W-1:0]               r_signed;
  logic [W-1:0]               value_next;

  assign accept = start && !busy;
  assign fn     = zalu_pkg::func_t'(func);
  assign a      = first_operand;
  assign b      = second_operand;
  assign a_abs  = a[W-1] ? (~a + 16'd1) : a;
  assign b_abs  = b[W-1] ? (~b + 16'd1) : b;

  assign neg_b      = ~b + 16'd1;
  assign shift_left = !b[W-1] && (b != '0);
  assign left_big   = b[W-1:4] != '0;
  assign right_big  = neg_b[W-1:4] != '0;
  assign shl        = a << b[3:0];
  assign shr_l      = a >> neg_b[3:0];
  assign shr_a      = W'($signed(a) >>> neg_b[3:0]);
  assign lsh_val    = shift_left ? (left_big ? '0 : shl) : (right_big ? '0 : shr_l);
  assign ash_val    = shift_left ? (left_big ? '0 : shl)
                                 : (right_big ? {W{a[W-1]}} : shr_a);

  assign cnt_lim = (operand_count > zalu_pkg::COUNT_W'(zalu_pkg::JE_LIMIT))
                 ? zalu_pkg::COUNT_W'(zalu_pkg::JE_LIMIT) : operand_count;

  always_comb begin
    side_next              = '0;
    side_next.func         = fn;
    side_next.q_neg        = a[W-1] ^ b[W-1];
    side_next.r_neg        = a[W-1];
    unique case (fn)
      zalu_pkg::FN_ADD: begin
        side_next.value       = a + b;
        side_next.value_valid = 1'b1;
      end
      zalu_pkg::FN_SUB: begin
        side_next.value       = a - b;
        side_next.value_valid = 1'b1;
      end
      zalu_pkg::FN_MUL: begin
        side_next.value       = W'(a * b);
        side_next.value_valid = 1'b1;
      end
      zalu_pkg::FN_DIV, zalu_pkg::FN_REM: begin
        side_next.value_valid = 1'b1;
        side_next.dz          = b == '0;
      end
      zalu_pkg::FN_SHIFT: begin
        side_next.value       = lsh_val;
        side_next.value_valid = 1'b1;
      end
      zalu_pkg::FN_ASHIFT: begin
        side_next.value       = ash_val;
        side_next.value_valid = 1'b1;
      end
      zalu_pkg::FN_OR: begin
        side_next.value       = a | b;
        side_next.value_valid = 1'b1;
      end
      zalu_pkg::FN_AND: begin
        side_next.value       = a & b;
        side_next.value_valid = 1'b1;
      end
      zalu_pkg::FN_NOT: begin
        side_next.value       = ~a;
        side_next.value_valid = 1'b1;
      end
      zalu_pkg::FN_TEST: begin
        side_next.cond         = (a & b) == b;
        side_next.branch_valid = 1'b1;
      end
      zalu_pkg::FN_JZ: begin
        side_next.cond         = a == '0;
        side_next.branch_valid = 1'b1;
      end
      zalu_pkg::FN_JE: begin
        side_next.cond = ((cnt_lim > 3'd1) && (second_operand == a))
                      || ((cnt_lim > 3'd2) && (third_operand == a))
                      || ((cnt_lim > 3'd3) && (fourth_operand == a));
        side_next.branch_valid = 1'b1;
      end
      zalu_pkg::FN_JL: begin
        side_next.cond         = $signed(a) < $signed(b);
        side_next.branch_valid = 1'b1;
      end
      zalu_pkg::FN_JG: begin
        side_next.cond         = $signed(a) > $signed(b);
        side_next.branch_valid = 1'b1;
      end
      default: begin
        side_next.value_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      s1_valid <= 1'b0;
    end else begin
      busy     <= 1'b0;
      s1_valid <= accept;
    end
    s1_side     <= side_next;
    s1_dividend <= a_abs;
    s1_divisor  <= b_abs;
  end

  zalu_div u_div (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (s1_valid),
    .in_side       (s1_side),
    .in_dividend   (s1_dividend),
    .in_divisor    (s1_divisor),
    .out_valid     (dv_valid),
    .out_side      (dv_side),
    .out_quotient  (dv_quo),
    .out_remainder (dv_rem)
  );

  assign q_signed = dv_side.q_neg ? (~dv_quo + 16'd1) : dv_quo;
  assign r_signed = dv_side.r_neg ? (~dv_rem + 16'd1) : dv_rem;

  always_comb begin
    priority if (dv_side.dz) begin
      value_next = '0;
    end else if (dv_side.func == zalu_pkg::FN_DIV) begin
      value_next = q_signed;
    end else if (dv_side.func == zalu_pkg::FN_REM) begin
      value_next = r_signed;
    end else begin
      value_next = dv_side.value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dv_valid;
    end
    result_value     <= value_next;
    value_valid      <= dv_side.value_valid;
    branch_condition <= dv_side.cond;
    branch_valid     <= dv_side.branch_valid;
    divide_by_zero   <= dv_side.dz;
  end

`ifndef NO_ASSERTIONS
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##(zalu_pkg::PIPE_LATENCY) done)
    else $error("accepted word did not produce a result on time");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, zalu_pkg::PIPE_LATENCY))
    else $error("result without a matching command");

  a_kind_exclusive: assert property (@(posedge clk) disable iff (rst)
    done |-> !(value_valid && branch_valid))
    else $error("result carries both a value and a branch condition");

  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    (done && divide_by_zero) |-> (value_valid && result_value == '0 && !branch_valid))
    else $error("divide by zero result malformed");

  a_cond_kind: assert property (@(posedge clk) disable iff (rst)
    (done && branch_condition) |-> branch_valid)
    else $error("branch condition without branch kind");
`endif

endmodule
